// File: src/utf8dec_pkg.sv
package utf8dec_pkg;

  // Decoder phase: what the next byte is expected to be
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,  // awaiting a lead byte
    PH_LAST  = 2'd1,  // awaiting the final continuation byte
    PH_MID   = 2'd2   // awaiting the middle byte of a 3-byte form
  } phase_e;

  // Byte classification masks and codes
  localparam logic [7:0] TOP_BIT_MASK  = 8'h80;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_CODE     = 8'h80;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;

  localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_run;
    logic [15:0] units_written;
    logic [15:0] bytes_consumed;
  } result_t;

endpackage

// File: src/utf8_to_utf16_decoder_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_ready_o   in_byte_i, last_in_run_i
// out      output     out_valid_o/out_ready_i code_unit_o, end_of_run_o,
//                                             units_written_o, bytes_consumed_o
// cfg      input      cfg_we_i                cfg_wdata_i (out_capacity)
//
// One byte per cycle while the result register has room. A byte waits
// in the input register; its results land in a two-entry result register.
// A byte that yields a unit and the end result holds the next byte back
// while the second result drains from the second result entry.
// Reset clears the phase, the run counters and both result entries; the
// capacity register returns to 65535. Output stalls back up into in_ready_o.
module utf8_to_utf16_decoder_unit
  import utf8dec_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        last_in_run_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        end_of_run_o,
  output logic [15:0] units_written_o,
  output logic [15:0] bytes_consumed_o
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Saturating add of a small increment
  function automatic logic [COUNT_BITS-1:0] sat_add(logic [COUNT_BITS-1:0] a,
                                                     logic [1:0] inc);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS+1)'(inc);
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  // Configuration register
  logic [15:0] cap_q;

  // Input register
  logic       in_v_q;
  logic [7:0] byte_q;
  logic       last_q;

  // Decoder state
  phase_e                phase_q, phase_d;
  logic [7:0]            lead_q, lead_d;
  logic [7:0]            fc_q, fc_d;
  logic [COUNT_BITS-1:0] uc_q, uc_d;
  logic [COUNT_BITS-1:0] bc_q, bc_d;
  logic [COUNT_BITS-1:0] lpos_q, lpos_d;
  logic                  disc_q, disc_d;

  // Result register: two entries, entry 0 drives the outputs
  logic    s0_v_q, s0_v_d, s1_v_q, s1_v_d;
  result_t s0_q, s0_d, s1_q, s1_d;

  // Step outputs
  logic [1:0] n_res;
  result_t    r0, r1;
  logic       proc, out_take;

  assign out_take   = s0_v_q && out_ready_i;
  assign proc       = in_v_q && !s1_v_q && (!s0_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || proc;

  // Decode step for the registered byte
  always_comb begin
    logic [15:0]           unit;
    logic [1:0]            used;
    logic                  lead2;
    logic                  do_emit;
    logic                  do_finish;
    logic [COUNT_BITS-1:0] fin_bytes;
    logic [COUNT_BITS-1:0] uc_n;
    logic [COUNT_BITS-1:0] bc_n;
    logic                  cap_hit;
    phase_d   = phase_q;
    lead_d    = lead_q;
    fc_d      = fc_q;
    uc_d      = uc_q;
    bc_d      = bc_q;
    lpos_d    = lpos_q;
    disc_d    = disc_q;
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;
    unit      = '0;
    used      = 2'd1;
    do_emit   = 1'b0;
    do_finish = 1'b0;
    fin_bytes = bc_q;
    lead2     = ((lead_q & LEAD2_MASK) == LEAD2_CODE);
    cap_hit   = (CMP_W'(uc_q) >= CMP_W'(cap_q));
    uc_n      = '0;
    bc_n      = '0;

    if (disc_q) begin
      if (last_q) begin
        disc_d = 1'b0;
      end
    end else begin
      case (phase_q)
        PH_LAST: begin
          do_emit = 1'b1;
          if (lead2) begin
            unit = {5'd0, lead_q[4:0], byte_q[5:0]};
            used = 2'd2;
          end else begin
            unit = {lead_q[3:0], fc_q[5:0], byte_q[5:0]};
            used = 2'd3;
          end
        end
        PH_MID: begin
          fc_d = byte_q;
          if (last_q) begin
            do_finish = 1'b1;
            fin_bytes = lpos_q;
          end else begin
            phase_d = PH_LAST;
          end
        end
        PH_LEAD: begin
          if (cap_hit || byte_q == 8'd0) begin
            do_finish = 1'b1;
            fin_bytes = bc_q;
          end else if ((byte_q & TOP_BIT_MASK) == 8'd0 ||
                       (byte_q & CONT_MASK) == CONT_CODE) begin
            do_emit = 1'b1;
            unit    = {8'd0, byte_q};
            used    = 2'd1;
          end else begin
            lead_d = byte_q;
            lpos_d = bc_q;
            if (last_q) begin
              do_finish = 1'b1;
              fin_bytes = bc_q;
            end else if ((byte_q & LEAD2_MASK) == LEAD2_CODE) begin
              phase_d = PH_LAST;
            end else begin
              phase_d = PH_MID;
            end
          end
        end
        default: begin
          phase_d = PH_LEAD;
        end
      endcase
    end

    // Unit result, possibly followed by the end result
    if (do_emit) begin
      uc_n          = sat_add(uc_q, 2'd1);
      bc_n          = sat_add(bc_q, used);
      r0.code_unit  = unit;
      n_res         = 2'd1;
      phase_d       = PH_LEAD;
      uc_d          = uc_n;
      bc_d          = bc_n;
      if ((CMP_W'(uc_n) >= CMP_W'(cap_q)) || last_q) begin
        r1.end_of_run     = 1'b1;
        r1.units_written  = 16'(uc_n);
        r1.bytes_consumed = 16'(bc_n);
        n_res             = 2'd2;
        uc_d              = '0;
        bc_d              = '0;
        lpos_d            = '0;
        disc_d            = !last_q;
      end
    end

    // End result alone
    if (do_finish) begin
      r0.end_of_run     = 1'b1;
      r0.units_written  = 16'(uc_q);
      r0.bytes_consumed = 16'(fin_bytes);
      n_res             = 2'd1;
      uc_d              = '0;
      bc_d              = '0;
      lpos_d            = '0;
      phase_d           = PH_LEAD;
      disc_d            = !last_q;
    end
  end

  // Result register next values
  always_comb begin
    s0_v_d = s0_v_q;
    s1_v_d = s1_v_q;
    s0_d   = s0_q;
    s1_d   = s1_q;
    if (proc) begin
      s0_v_d = (n_res != 2'd0);
      s1_v_d = (n_res == 2'd2);
      s0_d   = r0;
      s1_d   = r1;
    end else if (out_take) begin
      s0_v_d = s1_v_q;
      s1_v_d = 1'b0;
      s0_d   = s1_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAPACITY_RESET;
      in_v_q  <= 1'b0;
      phase_q <= PH_LEAD;
      lead_q  <= '0;
      fc_q    <= '0;
      uc_q    <= '0;
      bc_q    <= '0;
      lpos_q  <= '0;
      disc_q  <= 1'b0;
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (proc) begin
        phase_q <= phase_d;
        lead_q  <= lead_d;
        fc_q    <= fc_d;
        uc_q    <= uc_d;
        bc_q    <= bc_d;
        lpos_q  <= lpos_d;
        disc_q  <= disc_d;
      end
      s0_v_q <= s0_v_d;
      s1_v_q <= s1_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
      last_q <= last_in_run_i;
    end
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign out_valid_o      = s0_v_q;
  assign code_unit_o      = s0_q.code_unit;
  assign end_of_run_o     = s0_q.end_of_run;
  assign units_written_o  = s0_q.units_written;
  assign bytes_consumed_o = s0_q.bytes_consumed;

endmodule

// File: src/utf8dec_checker.sv
module utf8dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] code_unit_o,
  input logic        end_of_run_o,
  input logic [15:0] units_written_o,
  input logic [15:0] bytes_consumed_o
);

  // End result always carries a zero code unit
  a_end_zero_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_run_o |-> code_unit_o == 16'd0)
    else $error("end result with nonzero code unit");

  // Unit results carry no counts
  a_unit_no_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_run_o |-> units_written_o == 16'd0 &&
                                     bytes_consumed_o == 16'd0)
    else $error("unit result with nonzero counts");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // No result is offered right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    rst_ni && $past(!rst_ni) |-> !out_valid_o)
    else $error("result offered after reset");

endmodule

bind utf8_to_utf16_decoder_unit utf8dec_checker u_utf8dec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .code_unit_o     (code_unit_o),
  .end_of_run_o    (end_of_run_o),
  .units_written_o (units_written_o),
  .bytes_consumed_o(bytes_consumed_o)
);
